// ===== src/drmf_pkg.sv =====
// Shared types and constants of the delta-R match filter.
package drmf_pkg;

  // Angle constants in 1/1024 units
  localparam logic signed [13:0] PI_FX     = 14'sd3217;
  localparam logic signed [13:0] TWO_PI_FX = 14'sd6434;

  // Reset value of the matching radius (0.5)
  localparam logic signed [13:0] RADIUS_RST = 14'sd512;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_CAND  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  // One stored reference candidate
  typedef struct packed {
    logic signed [13:0] eta;
    logic signed [12:0] phi;
  } cand_t;

  // Write port of the candidate memory
  typedef struct packed {
    logic  we;
    cand_t wdata;
  } cand_wr_t;

endpackage

// ===== src/drmf_cand_mem.sv =====
// Candidate table: one write port, one registered read port.
module drmf_cand_mem
  import drmf_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  cand_wr_t         wr_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output cand_t            rdata_o
);

  cand_t mem_q [DEPTH];
  cand_t rdata_q;

  // Write a candidate
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr_i] <= wr_i.wdata;
    end
  end

  // Read one entry per cycle into the output register
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/drmf_square.sv =====
// Shared squaring unit with a registered result.
module drmf_square (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [14:0] op_i,
  output logic        [27:0] sq_o
);

  logic signed [29:0] prod;
  logic        [27:0] sq_q;

  // Square the operand; |op| <= 16383 keeps the result in 28 bits
  assign prod = op_i * op_i;

  // Hold the result unless a new square is requested
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= prod[27:0];
    end
  end

  assign sq_o = sq_q;

endmodule

// ===== src/angular_delta_r_match_filter.sv =====
// Top level of the delta-R match filter: sequencer, table count and stream ports.
// Clear and load items leave the sequencer idle, so the block stays ready.
// A query squares the radius once, then for each stored candidate (stopping early
// on a match) steps through read, difference, two squarings on the shared squarer
// and a compare. A match waits in the compare until the output can take the tag.
// A result waits in the output register while the next item is taken.
// Reset clears the candidate count and the output valid and sets the radius to 0.5.
module angular_delta_r_match_filter
  import drmf_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: match_radius
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // eta[13:0], phi[26:14], cand_energy[37:27], bunch_offset[40:38],
  // jet_tag[48:41], zero pad[55:49]
  input  logic [55:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // passed_tag[7:0]
  output logic [7:0]  m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_THR  = 7'b0000010,
    ST_RD   = 7'b0000100,
    ST_DIFF = 7'b0001000,
    ST_SQE  = 7'b0010000,
    ST_SQP  = 7'b0100000,
    ST_CMP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [13:0] radius_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic signed [13:0] jet_eta_q;
  logic signed [12:0] jet_phi_q;
  logic [7:0]         jet_tag_q;
  logic signed [14:0] de_q;
  logic signed [13:0] dp_q;
  logic [27:0]        acc_q;
  logic signed [28:0] thr_q;
  logic               m_valid_q;
  logic [7:0]         m_tag_q;

  // Input fields
  logic               s_xfer;
  logic signed [13:0] in_eta;
  logic signed [12:0] in_phi;
  logic [10:0]        in_energy;
  logic signed [2:0]  in_bx;
  logic [7:0]         in_tag;
  kind_e              in_kind;

  assign in_eta    = s_axis_tdata_i[13:0];
  assign in_phi    = s_axis_tdata_i[26:14];
  assign in_energy = s_axis_tdata_i[37:27];
  assign in_bx     = s_axis_tdata_i[40:38];
  assign in_tag    = s_axis_tdata_i[48:41];
  assign in_kind   = kind_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  // Candidate table
  cand_wr_t cand_wr;
  cand_t    cand_rd;

  assign cand_wr.we = s_xfer && (in_kind == KIND_CAND) && (in_energy != 11'd0) &&
                      (in_bx == 3'sd0) && (cnt_q < CNT_W'(MAX_CANDIDATES));
  assign cand_wr.wdata.eta = in_eta;
  assign cand_wr.wdata.phi = in_phi;

  drmf_cand_mem #(
    .DEPTH (MAX_CANDIDATES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .wr_i    (cand_wr),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (cand_rd)
  );

  // Shared squarer: radius, eta difference, phi difference
  logic               sq_en;
  logic signed [14:0] sq_op;
  logic [27:0]        sq;
  logic signed [14:0] radius_ext;
  logic signed [14:0] radius_abs;

  assign radius_ext = {radius_q[13], radius_q};
  assign radius_abs = radius_ext[14] ? -radius_ext : radius_ext;

  always_comb begin
    sq_en = 1'b0;
    sq_op = de_q;
    unique case (state_q)
      ST_THR: begin
        sq_en = 1'b1;
        sq_op = radius_abs;
      end
      ST_SQE: begin
        sq_en = 1'b1;
        sq_op = de_q;
      end
      ST_SQP: begin
        sq_en = 1'b1;
        sq_op = {dp_q[13], dp_q};
      end
      default: begin
        sq_en = 1'b0;
      end
    endcase
  end

  drmf_square u_sq (
    .clk_i (clk_i),
    .en_i  (sq_en),
    .op_i  (sq_op),
    .sq_o  (sq)
  );

  // Differences against the candidate just read, phi wrapped into [-pi, pi)
  logic signed [14:0] de;
  logic signed [13:0] dp_raw;
  logic signed [13:0] dp;

  assign de     = {jet_eta_q[13], jet_eta_q} - {cand_rd.eta[13], cand_rd.eta};
  assign dp_raw = {jet_phi_q[12], jet_phi_q} - {cand_rd.phi[12], cand_rd.phi};

  always_comb begin
    if (dp_raw >= PI_FX) begin
      dp = dp_raw - TWO_PI_FX;
    end else if (dp_raw < -PI_FX) begin
      dp = dp_raw + TWO_PI_FX;
    end else begin
      dp = dp_raw;
    end
  end

  // Sum of squares against the signed threshold
  logic [28:0] sum_sq;
  logic        hit;
  logic        out_free;
  logic        out_load;

  assign sum_sq   = {1'b0, acc_q} + {1'b0, sq};
  assign hit      = $signed({1'b0, sum_sq}) < $signed({thr_q[28], thr_q});
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          case (in_kind)
            KIND_EVENT: cnt_d = '0;
            KIND_CAND: begin
              if (cand_wr.we) begin
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            KIND_QUERY: begin
              idx_d = '0;
              if (cnt_q != '0) begin
                state_d = ST_THR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_THR:  state_d = ST_RD;
      ST_RD:   state_d = ST_DIFF;
      ST_DIFF: state_d = ST_SQE;
      ST_SQE:  state_d = ST_SQP;
      ST_SQP:  state_d = ST_CMP;
      ST_CMP: begin
        if (hit) begin
          // Wait until the output register can take the tag
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (idx_q + CNT_W'(1) == cnt_q) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      radius_q  <= RADIUS_RST;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      jet_eta_q <= in_eta;
      jet_phi_q <= in_phi;
      jet_tag_q <= in_tag;
    end
    // Latch the threshold once per query, keeping the radius sign
    if (state_q == ST_RD && idx_q == '0) begin
      thr_q <= radius_q[13] ? -$signed({1'b0, sq}) : $signed({1'b0, sq});
    end
    if (state_q == ST_DIFF) begin
      de_q <= de;
      dp_q <= dp;
    end
    // Hold eta difference squared while the phi square is formed
    if (state_q == ST_SQP) begin
      acc_q <= sq;
    end
    if (out_load) begin
      m_tag_q <= jet_tag_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_tag_q;

endmodule

// ===== src/drmf_checker.sv =====
// Port-level checks of the delta-R match filter, bound to the top level.
module drmf_checker
  import drmf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  // Clear, load and ignored items leave the input ready in the next cycle
  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != KIND_QUERY)
    |=> s_axis_tready_o)
    else $error("non-query item kept the input stalled");

  // A new result only comes out of a running query
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared while idle");

  // A result is replaced only after the previous one was taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i && !s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("pending result lost during a query");

endmodule

bind angular_delta_r_match_filter drmf_checker u_drmf_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the delta-R match filter: event streams against a built-in predictor.
module tb
  import drmf_pkg::*;
();

  localparam logic [1:0]  KIND_SPARE    = 2'd3;
  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned ITEM_TARGET   = 1500;
  localparam int unsigned N_PHASES      = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [13:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;

  // Predicts passed tags from accepted transfers and checks the output stream
  class jet_match_board;
    logic signed [13:0] radius;
    logic signed [13:0] eta_tab [TABLE_DEPTH];
    logic signed [12:0] phi_tab [TABLE_DEPTH];
    int unsigned        n_stored;
    logic [7:0]         tags_due [$];
    int unsigned        errors, queries, passed, kept, rejected, dropped_full;

    function new();
      radius       = RADIUS_RST;
      n_stored     = 0;
      errors       = 0;
      queries      = 0;
      passed       = 0;
      kept         = 0;
      rejected     = 0;
      dropped_full = 0;
    endfunction

    // Fold an azimuth difference once by 2*pi toward [-pi, pi)
    function longint wrap_dphi(longint d);
      if (d >= longint'(PI_FX)) return d - longint'(TWO_PI_FX);
      if (d < -longint'(PI_FX)) return d + longint'(TWO_PI_FX);
      return d;
    endfunction

    function void note_transfer(logic [1:0] kind, logic [55:0] data);
      logic signed [13:0] eta;
      logic signed [12:0] phi;
      logic [10:0]        energy;
      logic signed [2:0]  bx;
      longint             thr, de, dp;
      eta    = data[13:0];
      phi    = data[26:14];
      energy = data[37:27];
      bx     = data[40:38];
      case (kind)
        KIND_EVENT: n_stored = 0;
        KIND_CAND: begin
          if (energy == 0 || bx != 0) begin
            rejected++;
          end else if (n_stored >= TABLE_DEPTH) begin
            dropped_full++;
          end else begin
            eta_tab[n_stored] = eta;
            phi_tab[n_stored] = phi;
            n_stored++;
            kept++;
          end
        end
        KIND_QUERY: begin
          queries++;
          // threshold keeps the sign of the radius
          thr = longint'(radius) * (radius < 0 ? -longint'(radius) : longint'(radius));
          for (int i = 0; i < n_stored; i++) begin
            de = longint'(eta) - longint'(eta_tab[i]);
            dp = wrap_dphi(longint'(phi) - longint'(phi_tab[i]));
            if (de * de + dp * dp < thr) begin
              tags_due.push_back(data[48:41]);
              break;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_tag(logic [7:0] tag);
      logic [7:0] want;
      if (tags_due.size() == 0) begin
        $display("%0t: passed tag mismatch: expected none, actual %0d", $time, tag);
        errors++;
      end else begin
        want = tags_due.pop_front();
        if (tag !== want) begin
          $display("%0t: passed tag mismatch: expected %0d, actual %0d", $time, want, tag);
          errors++;
        end else begin
          passed++;
        end
      end
    endfunction
  endclass

  jet_match_board board = new();
  bit             steady = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    radius_writes = 0;
  int unsigned    idle_cycles = 0;

  angular_delta_r_match_filter #(
    .MAX_CANDIDATES(TABLE_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, none while steady
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Azimuth mostly inside [-pi, pi), sometimes anywhere in 13 bits
  function automatic logic [12:0] rand_phi();
    int v;
    if ($urandom_range(0, 9) == 0) return 13'($urandom);
    v = int'($urandom_range(0, 6433)) - 3217;
    return v[12:0];
  endfunction

  // Offset on the scale of the current radius, so queries land on both sides of it
  function automatic int near_offset();
    int span;
    span = board.radius < 0 ? -int'(board.radius) : int'(board.radius);
    span = span + span / 2 + 2;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Check results, note inputs and watch for a stalled run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_tag(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o) board.note_transfer(s_axis_tuser_i, s_axis_tdata_i);
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stall the output stream at random
  initial begin
    int unsigned gap;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [13:0] eta,
                           input logic [12:0] phi, input logic [10:0] energy,
                           input logic [2:0] bx, input logic [7:0] tag);
    int unsigned gap;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {7'd0, tag, bx, energy, phi, eta};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (kind != KIND_SPARE) items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the input until every tag has come out, then let a long query finish
  task automatic drain_and_settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.tags_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [13:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    board.radius = value;
    radius_writes++;
  endtask

  task automatic send_noise();
    send_item(KIND_SPARE, 14'($urandom), 13'($urandom), 11'($urandom), 3'($urandom),
              8'($urandom));
  endtask

  // One event: usually a clear, a batch of candidates, then queries mostly near them
  task automatic run_event();
    logic signed [13:0] seen_eta [$];
    logic signed [12:0] seen_phi [$];
    int unsigned        n_cand, n_query, pick;
    int unsigned        roll;
    logic [13:0]        eta;
    logic [12:0]        phi;
    logic [10:0]        energy;
    logic [2:0]         bx;
    if ($urandom_range(0, 99) < 85) begin
      send_item(KIND_EVENT, 14'($urandom), 13'($urandom), 11'($urandom), 3'($urandom),
                8'($urandom));
    end
    n_cand = ($urandom_range(0, 99) < 15) ? $urandom_range(10, 20) : $urandom_range(0, 6);
    repeat (n_cand) begin
      eta    = 14'($urandom);
      phi    = rand_phi();
      energy = 11'($urandom_range(1, 2047));
      bx     = 3'd0;
      roll   = $urandom_range(0, 99);
      if (roll < 8) energy = 11'd0;
      else if (roll < 16) bx = 3'($urandom_range(1, 7));
      seen_eta.push_back(eta);
      seen_phi.push_back(phi);
      send_item(KIND_CAND, eta, phi, energy, bx, 8'($urandom));
      if ($urandom_range(0, 99) < 3) send_noise();
    end
    n_query = $urandom_range(1, 6);
    repeat (n_query) begin
      if (seen_eta.size() != 0 && $urandom_range(0, 99) < 75) begin
        pick = $urandom_range(0, seen_eta.size() - 1);
        eta  = 14'(int'(seen_eta[pick]) + near_offset());
        phi  = 13'(int'(seen_phi[pick]) + near_offset());
      end else begin
        eta = 14'($urandom);
        phi = rand_phi();
      end
      send_item(KIND_QUERY, eta, phi, 11'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [13:0] radius_plan [N_PHASES];
    int unsigned phase_goal;
    radius_plan = '{14'sd512, 14'sd8191, -14'sd8192, 14'sd0, 14'sd1, -14'sd300,
                    14'sd1500, 14'sd200};
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= KIND_EVENT;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, field extremes, skipped candidates, phi wrap, ignored kind
    send_item(KIND_QUERY, 14'sd0, 13'sd0, 11'd0, 3'd0, 8'd1);
    send_item(KIND_CAND, -14'sd8192, -13'sd4096, 11'd2047, 3'd0, 8'd0);
    send_item(KIND_CAND, 14'sd0, 13'sd0, 11'd0, 3'd0, 8'd255);
    send_item(KIND_CAND, 14'sd0, 13'sd0, 11'd2047, -3'sd4, 8'd0);
    send_item(KIND_CAND, 14'sd0, 13'sd3216, 11'd1, 3'd0, 8'd0);
    send_item(KIND_SPARE, 14'sd0, 13'sd0, 11'd2047, 3'd3, 8'd255);
    send_item(KIND_QUERY, -14'sd8192, -13'sd4096, 11'd2047, 3'd7, 8'd255);
    send_item(KIND_QUERY, 14'sd0, -13'sd3217, 11'd0, 3'd0, 8'ha5);
    send_item(KIND_QUERY, 14'sd8191, 13'sd4095, 11'd0, 3'd0, 8'd0);
    send_item(KIND_QUERY, 14'sd0, 13'sd0, 11'd0, 3'd0, 8'h33);
    send_item(KIND_EVENT, 14'sd8191, 13'sd4095, 11'd2047, 3'd7, 8'd255);
    send_item(KIND_QUERY, 14'sd0, 13'sd3216, 11'd0, 3'd0, 8'd7);
    // Fill the table, then one candidate too many
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(KIND_CAND, 14'(i * 64 - 512), 13'(i * 100), 11'd3, 3'd0, 8'd0);
    end
    send_item(KIND_CAND, 14'sd8191, 13'sd4095, 11'd2047, 3'd0, 8'd0);
    send_item(KIND_QUERY, 14'sd8191, 13'sd4095, 11'd0, 3'd0, 8'hc3);

    // Random events, one radius per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        drain_and_settle();
        write_radius(ph == N_PHASES - 1 ? 14'($urandom) : radius_plan[ph]);
      end
      steady     = (ph % 3 == 2);
      phase_goal = ITEM_TARGET * (ph + 1) / N_PHASES;
      while (items_sent < phase_goal) begin
        run_event();
        if ($urandom_range(0, 49) == 0) drain_and_settle();
      end
    end
    drain_and_settle();

    if (board.tags_due.size() != 0) begin
      $display("%0t: %0d passed tags never arrived, first expected %0d", $time,
               board.tags_due.size(), board.tags_due[0]);
    end
    $display("Run covered %0d items over %0d radius settings: %0d queries, %0d tags passed.",
             items_sent, radius_writes + 1, board.queries, board.passed);
    $display("Candidates: %0d stored, %0d skipped for energy or bunch, %0d dropped on full table.",
             board.kept, board.rejected, board.dropped_full);
    if (board.errors == 0 && board.tags_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/drmf_pkg.sv
src/drmf_cand_mem.sv
src/drmf_square.sv
src/angular_delta_r_match_filter.sv
src/drmf_checker.sv
sim/tb.sv
